[rtl/core/rtcf_pkg.sv]
// ----------------------------------------------------------------------------
// RGB crossfade package
// Shared widths, reset values, handshake types and channel helpers used by
// the crossfade top level and its step divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcf_pkg;

   // Field widths.
   localparam int COLOR_W = 24;
   localparam int TICK_W  = 32;
   localparam int SPAN_W  = 24;
   localparam int CHAN_W  = 8;

   // Quotient of the step divider: a step never exceeds the channel maximum.
   localparam int STEP_W  = CHAN_W;

   // Full-scale channel value used by the step and blend math.
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // Fade length after reset, in timer ticks.
   localparam logic [SPAN_W-1:0] TICKS_RESET = 24'd500;

   // Channel positions inside a packed color.
   localparam logic [1:0] CH_BLUE  = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_RED   = 2'd2;

   // Status of the step divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Pick one 8-bit channel out of a packed color.
   function automatic logic [CHAN_W-1:0] get_chan(input logic [COLOR_W-1:0] color,
                                                  input logic [1:0]         idx);
      logic [CHAN_W-1:0] chan;
      unique case (idx)
         CH_RED:   chan = color[23:16];
         CH_GREEN: chan = color[15:8];
         default:  chan = color[7:0];
      endcase
      return chan;
   endfunction

   // Replace one 8-bit channel of a packed color.
   function automatic logic [COLOR_W-1:0] put_chan(input logic [COLOR_W-1:0] color,
                                                   input logic [1:0]         idx,
                                                   input logic [CHAN_W-1:0]  chan);
      logic [COLOR_W-1:0] res;
      res = color;
      unique case (idx)
         CH_RED:   res[23:16] = chan;
         CH_GREEN: res[15:8]  = chan;
         default:  res[7:0]   = chan;
      endcase
      return res;
   endfunction

endpackage : rtcf_pkg

`default_nettype wire

[rtl/core/rtcf_div.sv]
// ----------------------------------------------------------------------------
// Crossfade step divider
// Computes floor(255 * elapsed / span) for elapsed <= span with one shared
// compare-and-subtract unit, one quotient bit per cycle into an 8-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcf_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [rtcf_pkg::SPAN_W-1:0]  elapsed,
   input  wire logic [rtcf_pkg::SPAN_W-1:0]  span,
   output rtcf_pkg::div_status_type          status,
   output logic      [rtcf_pkg::STEP_W-1:0]  quot
);
   import rtcf_pkg::*;

   localparam int CNT_W = $clog2(STEP_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [TICK_W-1:0]    rem_ff, rem_in;
   logic [TICK_W-1:0]    dsr_ff, dsr_in;
   logic [STEP_W-1:0]    quot_ff, quot_in;
   logic                 fits;

   // The shared unit: one compare and one subtract of the partial remainder.
   assign fits = (rem_ff >= dsr_ff);

   // Step sequencer: load the scaled numerator, then one bit per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEP_W - 1);
         // 255 * elapsed as a shift and a subtract.
         rem_in  = {elapsed, 8'b0} - {8'b0, elapsed};
         dsr_in  = {1'b0, span, 7'b0};
         quot_in = '0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[STEP_W-2:0], fits};
         if (fits) begin
            rem_in = rem_ff - dsr_ff;
         end
         dsr_in = {1'b0, dsr_ff[TICK_W-1:1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = quot_ff;

   // A start is only issued to an idle divider.
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");

   // The done pulse closes a busy run.
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("divider done without a run");

   // While running, the remainder stays below twice the current divisor step.
   assert property (@(posedge clock) disable iff (reset)
                    (busy_ff && !$past(start)) |-> (rem_ff < {dsr_ff, 1'b0}))
      else $error("divider remainder out of range");

endmodule : rtcf_div

`default_nettype wire

[rtl/core/rgb_target_crossfade_unit.sv]
// ----------------------------------------------------------------------------
// RGB target crossfade unit
// Turns a stream of requested colors and timer samples into the color to
// drive, fading linearly from the settled color to a new target.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per timer sample: the requested color and
//   the free-running tick count. req_stall is high while a transaction is in
//   work, so only one transaction is in flight at a time.
//   rsp_* returns exactly one drive color per request transaction, held in an
//   output register. A new request is taken while that result still waits.
//   csr_* writes the fade length in ticks; csr_ready is high when idle.
// Sequence:
//   A request that needs no blending passes through the evaluation step and
//   the output step.
//   A blended request passes through the evaluation step, a step division
//   by the fade length (one quotient bit per cycle through a single
//   compare-and-subtract unit), a multiply and a scale step per color
//   channel, and the output step.
//   The next request can be accepted as soon as the result is registered.
// Reset:
//   Synchronous, active high. The settled color becomes black, no fade is in
//   progress and the fade length returns to 500 ticks.
// Stall:
//   When rsp_stall holds a result, a finished transaction waits in its last
//   step and req_stall stays high until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_target_crossfade_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Request channel.
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [rtcf_pkg::COLOR_W-1:0] req_target_color,
   input  wire logic [rtcf_pkg::TICK_W-1:0]  req_tick_count,
   // Response channel.
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [rtcf_pkg::COLOR_W-1:0] rsp_drive_color,
   // Configuration write channel.
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [rtcf_pkg::SPAN_W-1:0]  csr_transition_ticks
);
   import rtcf_pkg::*;

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EVAL  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_SCALE = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [SPAN_W-1:0]   ticks_ff, ticks_in;
   logic [TICK_W-1:0]   start_ff, start_in;
   logic [COLOR_W-1:0]  settled_ff, settled_in;
   logic                fading_ff, fading_in;
   logic [COLOR_W-1:0]  target_ff, target_in;
   logic [TICK_W-1:0]   now_ff, now_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [1:0]          ch_ff, ch_in;
   logic [15:0]         prod_ff, prod_in;
   logic                neg_ff, neg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;

   logic                req_accept;
   logic                mismatch;
   logic [TICK_W-1:0]   start_eff;
   logic [TICK_W-1:0]   elapsed;
   logic [SPAN_W-1:0]   span;
   logic                over;
   logic                div_start;
   div_status_type      div_stat;
   logic [STEP_W-1:0]   div_quot;

   logic [CHAN_W-1:0]   chan_a;
   logic [CHAN_W-1:0]   chan_b;
   logic [CHAN_W:0]     diff;
   logic [CHAN_W:0]     diff_neg;
   logic [CHAN_W-1:0]   mag;
   logic [23:0]         recip;
   logic [CHAN_W-1:0]   q0;
   logic [15:0]         q0_x255;
   logic [15:0]         rem;
   logic [CHAN_W-1:0]   quo;
   logic [CHAN_W-1:0]   chan_out;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);

   // Fade evaluation: elapsed ticks since the fade started, modulo 2^32.
   assign mismatch  = (target_ff != settled_ff);
   assign start_eff = fading_ff ? start_ff : now_ff;
   assign elapsed   = now_ff - start_eff;
   assign span      = (ticks_ff == '0) ? SPAN_W'(1) : ticks_ff;
   assign over      = (elapsed > {8'b0, span});
   assign div_start = (state_ff == ST_EVAL) && mismatch && !over;

   rtcf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .elapsed (elapsed[SPAN_W-1:0]),
      .span    (span),
      .status  (div_stat),
      .quot    (div_quot)
   );

   // Channel difference magnitude and sign for the multiply step.
   assign chan_a   = get_chan(settled_ff, ch_ff);
   assign chan_b   = get_chan(target_ff, ch_ff);
   assign diff     = {1'b0, chan_b} - {1'b0, chan_a};
   assign diff_neg = '0 - diff;
   assign mag      = diff[CHAN_W] ? diff_neg[CHAN_W-1:0] : diff[CHAN_W-1:0];

   // Division of the product by 255: reciprocal 257/65536, then one correction.
   assign recip    = {prod_ff, 8'b0} + {8'b0, prod_ff};
   assign q0       = recip[23:16];
   assign q0_x255  = {q0, 8'b0} - {8'b0, q0};
   assign rem      = prod_ff - q0_x255;
   assign quo      = (rem >= {8'b0, CHAN_MAX}) ? q0 + CHAN_W'(1) : q0;
   assign chan_out = neg_ff ? chan_a - quo : chan_a + quo;

   // Sequencer and fade state update.
   always_comb begin
      state_in     = state_ff;
      ticks_in     = ticks_ff;
      start_in     = start_ff;
      settled_in   = settled_ff;
      fading_in    = fading_ff;
      target_in    = target_ff;
      now_in       = now_ff;
      color_in     = color_ff;
      step_in      = step_ff;
      ch_in        = ch_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_color_in = rsp_color_ff;

      if (csr_valid && csr_ready) begin
         ticks_in = csr_transition_ticks;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               target_in = req_target_color;
               now_in    = req_tick_count;
               state_in  = ST_EVAL;
            end
         end
         ST_EVAL: begin
            color_in = target_ff;
            if (!mismatch) begin
               state_in = ST_OUT;
            end else begin
               if (!fading_ff) begin
                  start_in  = now_ff;
                  fading_in = 1'b1;
               end
               if (over) begin
                  // Fade complete: the target becomes the shown color.
                  settled_in = target_ff;
                  fading_in  = 1'b0;
                  state_in   = ST_OUT;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               step_in  = div_quot;
               ch_in    = CH_RED;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = 16'(mag) * 16'(step_ff);
            neg_in   = diff[CHAN_W];
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            color_in = put_chan(color_ff, ch_ff, chan_out);
            if (ch_ff == CH_BLUE) begin
               state_in = ST_OUT;
            end else begin
               ch_in    = ch_ff - 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = color_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers: control and fade state reset, datapath holds.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ticks_ff     <= TICKS_RESET;
         start_ff     <= '0;
         settled_ff   <= '0;
         fading_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ticks_ff     <= ticks_in;
         start_ff     <= start_in;
         settled_ff   <= settled_in;
         fading_ff    <= fading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff    <= target_in;
      now_ff       <= now_in;
      color_ff     <= color_in;
      step_ff      <= step_in;
      ch_ff        <= ch_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_color = rsp_color_ff;

   // An accepted transaction is evaluated in the next cycle.
   assert property (@(posedge clock) disable iff (reset) req_accept |=> state_ff == ST_EVAL)
      else $error("accepted transaction not evaluated");

   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
                    div_stat.done |-> state_ff == ST_DIV)
      else $error("divider result outside the divide step");

   // The divider only runs while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
                    div_stat.busy |-> state_ff == ST_DIV)
      else $error("divider running outside the divide step");

   // Ending a fade settles on the target and clears the fade flag.
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_EVAL && mismatch && over)
                    |=> (settled_ff == $past(target_ff)) && !fading_ff)
      else $error("fade end did not settle");

   // A new result only appears out of the output step.
   assert property (@(posedge clock) disable iff (reset)
                    $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result produced outside the output step");

endmodule : rgb_target_crossfade_unit

`default_nettype wire
